// File: rtl/clq_pkg.sv
// ============================================================================
// clq_pkg
// Shared types and constants for the circular linked queue manager: sizes,
// status codes, micro-operations and the control and flag bundles that pass
// between the sequencer and the datapath.
// ============================================================================
`default_nettype none

package clq_pkg;

    // Pool and queue sizes.
    localparam int NUM_ELEMENTS = 64;
    localparam int NUM_QUEUES   = 4;

    // Internal widths follow from the sizes.
    localparam int ELEM_W  = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
    localparam int QUEUE_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int CNT_W   = $clog2(NUM_ELEMENTS + 1);

    // Fixed widths of the request and response fields.
    localparam int QID_W    = 2;
    localparam int EID_W    = 6;
    localparam int STATUS_W = 2;
    localparam int SIZE_W   = 7;
    localparam int HEAD_W   = 6;

    // Sequencer step counter width.
    localparam int PC_W = 3;

    typedef logic [ELEM_W-1:0]  elem_t;
    typedef logic [QUEUE_W-1:0] queue_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [PC_W-1:0]    pc_t;

    // Request action codes.
    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_LINKED     = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_NOT_MEMBER = 2'd3
    } status_t;

    // Datapath micro-operations.
    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_DISPATCH = 3'd1,
        OP_APPEND_A = 3'd2,
        OP_APPEND_B = 3'd3,
        OP_REMOVE   = 3'd4
    } op_t;

    // Jump conditions of the sequencer.
    typedef enum logic [1:0] {
        COND_NEVER      = 2'd0,
        COND_ALWAYS     = 2'd1,
        COND_REM_OR_REJ = 2'd2,
        COND_WAS_EMPTY  = 2'd3
    } cond_t;

    // One control word of the microprogram.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
        logic  finish;
    } uword_t;

    // Sequencer to datapath.
    typedef struct packed {
        op_t  op;
        logic accept;
        logic out_load;
    } ctl_t;

    // Datapath to sequencer.
    typedef struct packed {
        logic rem_or_rej;
        logic was_empty;
        logic out_free;
    } flags_t;

endpackage

`default_nettype wire

// File: rtl/clq_req_if.sv
// ============================================================================
// clq_req_if
// Request channel: valid/ready handshake with action, queue and element.
// ============================================================================
`default_nettype none

interface clq_req_if
    import clq_pkg::*;
();

    logic             valid;
    logic             ready;
    logic             action;
    logic [QID_W-1:0] queue_id;
    logic [EID_W-1:0] element_id;

    modport source (
        output valid,
        output action,
        output queue_id,
        output element_id,
        input  ready
    );

    modport sink (
        input  valid,
        input  action,
        input  queue_id,
        input  element_id,
        output ready
    );

endinterface

`default_nettype wire

// File: rtl/clq_rsp_if.sv
// ============================================================================
// clq_rsp_if
// Response channel: valid/ready handshake with status, size and queue head.
// ============================================================================
`default_nettype none

interface clq_rsp_if
    import clq_pkg::*;
();

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   occupancy;
    logic [HEAD_W-1:0]   head_element;
    logic                head_valid;

    modport source (
        output valid,
        output status,
        output occupancy,
        output head_element,
        output head_valid,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  occupancy,
        input  head_element,
        input  head_valid,
        output ready
    );

endinterface

`default_nettype wire

// File: rtl/clq_seq.sv
// ============================================================================
// clq_seq
// Microcoded sequencer: a step counter walks a read-only program whose
// control words drive the datapath and branch on datapath flags.
// ============================================================================
`default_nettype none

module clq_seq
    import clq_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   req_valid,
    output logic   req_ready,
    input  flags_t flags,
    output ctl_t   ctl
);

    localparam int UCODE_LEN = 5;

    localparam pc_t STEP_DISPATCH = PC_W'(0);
    localparam pc_t STEP_APPEND_A = PC_W'(1);
    localparam pc_t STEP_APPEND_B = PC_W'(2);
    localparam pc_t STEP_REMOVE   = PC_W'(3);
    localparam pc_t STEP_FINISH   = PC_W'(4);

    // Microprogram. Refused requests go through the remove step, which
    // leaves everything alone once the status is not ok.
    localparam uword_t UCODE [UCODE_LEN] = '{
        '{op: OP_DISPATCH, cond: COND_REM_OR_REJ, target: STEP_REMOVE,   finish: 1'b0},
        '{op: OP_APPEND_A, cond: COND_WAS_EMPTY,  target: STEP_FINISH,   finish: 1'b0},
        '{op: OP_APPEND_B, cond: COND_ALWAYS,     target: STEP_FINISH,   finish: 1'b0},
        '{op: OP_REMOVE,   cond: COND_NEVER,      target: STEP_DISPATCH, finish: 1'b0},
        '{op: OP_NONE,     cond: COND_NEVER,      target: STEP_DISPATCH, finish: 1'b1}
    };

    logic   busy_reg;
    logic   busy_next;
    pc_t    pc_reg;
    pc_t    pc_next;
    uword_t uw;
    logic   take_jump;
    logic   accept;
    logic   out_load;

    // Current control word.
    assign uw = UCODE[pc_reg];

    // Branch condition select.
    always_comb
    begin
        unique case (uw.cond)
            COND_NEVER:      take_jump = 1'b0;
            COND_ALWAYS:     take_jump = 1'b1;
            COND_REM_OR_REJ: take_jump = flags.rem_or_rej;
            COND_WAS_EMPTY:  take_jump = flags.was_empty;
        endcase
    end

    // A new request is taken when idle or in the finish step that frees up.
    assign out_load  = busy_reg && uw.finish && flags.out_free;
    assign req_ready = !busy_reg || (uw.finish && flags.out_free);
    assign accept    = req_valid && req_ready;

    assign ctl.op       = busy_reg ? uw.op : OP_NONE;
    assign ctl.accept   = accept;
    assign ctl.out_load = out_load;

    // Step counter and busy flag.
    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            pc_next   = STEP_DISPATCH;
        end
        else if (out_load)
        begin
            busy_next = 1'b0;
            pc_next   = STEP_DISPATCH;
        end
        else if (busy_reg && !uw.finish)
        begin
            pc_next = take_jump ? uw.target : PC_W'(pc_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= STEP_DISPATCH;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    // The step counter stays inside the program.
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (32'(pc_reg) < UCODE_LEN))
        else $error("step counter left the microprogram");

    // A request is never taken in the middle of a program run.
    a_accept_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!busy_reg || uw.finish))
        else $error("request taken while a program was still running");

endmodule

`default_nettype wire

// File: rtl/clq_datapath.sv
// ============================================================================
// clq_datapath
// Link memories, per-element and per-queue state, status and response
// register. Each micro-operation performs one step of append or remove.
// ============================================================================
`default_nettype none

module clq_datapath
    import clq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctl_t                ctl,
    output flags_t              flags,
    input  logic                req_action,
    input  logic [QID_W-1:0]    req_queue_id,
    input  logic [EID_W-1:0]    req_element_id,
    input  logic                rsp_ready,
    output logic                rsp_valid,
    output logic [STATUS_W-1:0] rsp_status,
    output logic [SIZE_W-1:0]   rsp_occupancy,
    output logic [HEAD_W-1:0]   rsp_head_element,
    output logic                rsp_head_valid
);

    // Captured request.
    logic             act_reg;
    logic [QID_W-1:0] qid_reg;
    logic [EID_W-1:0] eid_reg;

    // Link and owner memories.
    elem_t  next_mem  [NUM_ELEMENTS];
    elem_t  prev_mem  [NUM_ELEMENTS];
    queue_t owner_mem [NUM_ELEMENTS];
    elem_t  next_rd_reg;
    elem_t  prev_rd_reg;
    queue_t owner_rd_reg;

    // Element and queue state.
    logic [NUM_ELEMENTS-1:0]    linked_reg;
    logic [NUM_ELEMENTS-1:0]    linked_next;
    elem_t [NUM_QUEUES-1:0]     head_reg;
    elem_t [NUM_QUEUES-1:0]     head_next;
    logic [NUM_QUEUES-1:0]      nonempty_reg;
    logic [NUM_QUEUES-1:0]      nonempty_next;
    cnt_t [NUM_QUEUES-1:0]      count_reg;
    cnt_t [NUM_QUEUES-1:0]      count_next;
    status_t                    status_reg;
    status_t                    status_next;

    // Response register.
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic [SIZE_W-1:0]   rsp_size_reg;
    logic [HEAD_W-1:0]   rsp_head_reg;
    logic                rsp_hv_reg;

    // Decoded request and current queue view.
    logic    q_ok;
    logic    e_ok;
    queue_t  q_idx;
    elem_t   e_idx;
    logic    e_linked;
    logic    cur_nonempty;
    elem_t   cur_head;
    cnt_t    cur_count;
    cnt_t    count_inc;
    cnt_t    count_dec;
    status_t early_status;

    // Memory port controls.
    logic  link_rd;
    elem_t prev_raddr;
    logic  nx_we;
    elem_t nx_waddr;
    elem_t nx_wdata;
    logic  pv_we;
    elem_t pv_waddr;
    elem_t pv_wdata;
    logic  ow_we;

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            act_reg <= req_action;
            qid_reg <= req_queue_id;
            eid_reg <= req_element_id;
        end
    end

    assign q_ok  = (32'(qid_reg) < NUM_QUEUES);
    assign e_ok  = (32'(eid_reg) < NUM_ELEMENTS);
    assign q_idx = QUEUE_W'(qid_reg);
    assign e_idx = ELEM_W'(eid_reg);

    assign e_linked     = e_ok && linked_reg[e_idx];
    assign cur_nonempty = q_ok && nonempty_reg[q_idx];
    assign cur_head     = q_ok ? head_reg[q_idx] : '0;
    assign cur_count    = q_ok ? count_reg[q_idx] : '0;
    assign count_inc    = CNT_W'(cur_count + 1'b1);
    assign count_dec    = CNT_W'(cur_count - 1'b1);

    // Checks that need no memory read.
    always_comb
    begin
        if (!q_ok)
        begin
            early_status = (act_reg == ACT_REMOVE) ? ST_EMPTY : ST_NOT_MEMBER;
        end
        else if (act_reg == ACT_APPEND)
        begin
            early_status = (!e_ok || e_linked) ? ST_LINKED : ST_OK;
        end
        else if (!cur_nonempty)
        begin
            early_status = ST_EMPTY;
        end
        else if (!e_linked)
        begin
            early_status = ST_NOT_MEMBER;
        end
        else
        begin
            early_status = ST_OK;
        end
    end

    assign prev_raddr = (act_reg == ACT_REMOVE) ? e_idx : cur_head;

    // Flags for the sequencer.
    assign flags.rem_or_rej = (act_reg == ACT_REMOVE) || (early_status != ST_OK);
    assign flags.was_empty  = !cur_nonempty;
    assign flags.out_free   = !rsp_valid_reg || rsp_ready;

    // Micro-operation decode.
    always_comb
    begin
        status_next   = status_reg;
        linked_next   = linked_reg;
        head_next     = head_reg;
        nonempty_next = nonempty_reg;
        count_next    = count_reg;
        link_rd       = 1'b0;
        nx_we         = 1'b0;
        nx_waddr      = e_idx;
        nx_wdata      = e_idx;
        pv_we         = 1'b0;
        pv_waddr      = e_idx;
        pv_wdata      = e_idx;
        ow_we         = 1'b0;
        unique case (ctl.op)
            OP_NONE:
            begin
            end
            OP_DISPATCH:
            begin
                status_next = early_status;
                link_rd     = 1'b1;
            end
            OP_APPEND_A:
            begin
                ow_we = 1'b1;
                nx_we = 1'b1;
                pv_we = 1'b1;
                if (!cur_nonempty)
                begin
                    // First element closes a ring on itself.
                    head_next[q_idx]     = e_idx;
                    nonempty_next[q_idx] = 1'b1;
                    linked_next[e_idx]   = 1'b1;
                    count_next[q_idx]    = count_inc;
                end
                else
                begin
                    // Hook the new element behind the old tail.
                    nx_waddr = prev_rd_reg;
                    pv_wdata = prev_rd_reg;
                end
            end
            OP_APPEND_B:
            begin
                // Close the ring from the new tail back to the head.
                nx_we              = 1'b1;
                nx_wdata           = cur_head;
                pv_we              = 1'b1;
                pv_waddr           = cur_head;
                linked_next[e_idx] = 1'b1;
                count_next[q_idx]  = count_inc;
            end
            OP_REMOVE:
            begin
                if (status_reg == ST_OK)
                begin
                    if (owner_rd_reg != q_idx)
                    begin
                        status_next = ST_NOT_MEMBER;
                    end
                    else
                    begin
                        if (next_rd_reg == e_idx)
                        begin
                            nonempty_next[q_idx] = 1'b0;
                            head_next[q_idx]     = '0;
                        end
                        else
                        begin
                            if (cur_head == e_idx)
                            begin
                                head_next[q_idx] = next_rd_reg;
                            end
                            nx_we    = 1'b1;
                            nx_waddr = prev_rd_reg;
                            nx_wdata = next_rd_reg;
                            pv_we    = 1'b1;
                            pv_waddr = next_rd_reg;
                            pv_wdata = prev_rd_reg;
                        end
                        linked_next[e_idx] = 1'b0;
                        if (cur_count != '0)
                        begin
                            count_next[q_idx] = count_dec;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Link memories: one access per memory per cycle.
    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_mem[nx_waddr] <= nx_wdata;
        end
        if (link_rd)
        begin
            next_rd_reg <= next_mem[e_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pv_we)
        begin
            prev_mem[pv_waddr] <= pv_wdata;
        end
        if (link_rd)
        begin
            prev_rd_reg <= prev_mem[prev_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ow_we)
        begin
            owner_mem[e_idx] <= q_idx;
        end
        if (link_rd)
        begin
            owner_rd_reg <= owner_mem[e_idx];
        end
    end

    // State with a defined reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linked_reg   <= '0;
            nonempty_reg <= '0;
            count_reg    <= '0;
        end
        else
        begin
            linked_reg   <= linked_next;
            nonempty_reg <= nonempty_next;
            count_reg    <= count_next;
        end
    end

    // Heads and status are only read once written.
    always_ff @(posedge clk)
    begin
        head_reg   <= head_next;
        status_reg <= status_next;
    end

    // Response register.
    always_comb
    begin
        if (ctl.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            rsp_status_reg <= status_reg;
            rsp_size_reg   <= SIZE_W'(cur_count);
            rsp_head_reg   <= cur_nonempty ? HEAD_W'(cur_head) : '0;
            rsp_hv_reg     <= cur_nonempty;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign rsp_status       = rsp_status_reg;
    assign rsp_occupancy    = rsp_size_reg;
    assign rsp_head_element = rsp_head_reg;
    assign rsp_head_valid   = rsp_hv_reg;

    // A queue holds elements exactly when its count is nonzero.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        q_ok |-> (cur_nonempty == (cur_count != '0)))
        else $error("queue count and non-empty flag disagree");

    // An accepted removal always finds a nonzero count.
    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_REMOVE && status_reg == ST_OK && owner_rd_reg == q_idx)
        |-> (cur_count != '0))
        else $error("removal from a queue whose count is zero");

    // A response is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!rsp_valid_reg || rsp_ready))
        else $error("response register overwritten before it was taken");

endmodule

`default_nettype wire

// File: rtl/circular_linked_queue_manager_unit.sv
// ============================================================================
// circular_linked_queue_manager_unit
// Circular doubly linked queue manager: appends elements to queue tails and
// removes them from anywhere in a queue, one request at a time.
// ============================================================================
// An append to a non-empty queue runs dispatch, append A, append B, finish;
// one to an empty queue skips append B; a removal or refusal runs dispatch,
// remove, finish. A new request waits for the finish step and a free response
// register. The single-ported next/prev link memories set the step count.
// Reset: queue counts, non-empty flags, linked flags and control clear
// asynchronously; link memories are not cleared and need no clearing pass.
`default_nettype none

module circular_linked_queue_manager_unit
    import clq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    clq_req_if.sink   req,
    clq_rsp_if.source rsp
);

    ctl_t   ctl;
    flags_t flags;

    // Microprogram sequencer.
    clq_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .flags     (flags),
        .ctl       (ctl)
    );

    // Link datapath and response register.
    clq_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .flags            (flags),
        .req_action       (req.action),
        .req_queue_id     (req.queue_id),
        .req_element_id   (req.element_id),
        .rsp_ready        (rsp.ready),
        .rsp_valid        (rsp.valid),
        .rsp_status       (rsp.status),
        .rsp_occupancy    (rsp.occupancy),
        .rsp_head_element (rsp.head_element),
        .rsp_head_valid   (rsp.head_valid)
    );

endmodule

`default_nettype wire
